[rtl/srfdc_pkg.sv]
`default_nettype none

package srfdc_pkg;

  localparam int DEPTH_DEF        = 64;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam int KIND_W  = 2;
  localparam int DATA_W  = 32;
  localparam int MAXC_W  = 6;
  localparam int FILL_W  = 6;
  localparam int DROP_W  = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] sample_bits;
    logic              batch_last;
    logic [MAXC_W-1:0] max_count;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              data_valid;
    logic              last;
    logic              accepted;
    logic              batch_end;
    logic [FILL_W-1:0] fill_level;
    logic [DROP_W-1:0] dropped_total;
  } res_t;

  typedef enum logic {
    BS_IDLE,
    BS_POP
  } back_state_t;

endpackage

`default_nettype wire

[rtl/srfdc_if.sv]
`default_nettype none

interface srfdc_in_if;
  import srfdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [DATA_W-1:0] sample_bits;
  logic              batch_last;
  logic [MAXC_W-1:0] max_count;

  modport source(output valid, output kind, output sample_bits, output batch_last,
                 output max_count, input ready);
  modport sink(input valid, input kind, input sample_bits, input batch_last,
               input max_count, output ready);
endinterface

interface srfdc_out_if;
  import srfdc_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data;
  logic              data_valid;
  logic              last;
  logic              accepted;
  logic              batch_end;
  logic [FILL_W-1:0] fill_level;
  logic [DROP_W-1:0] dropped_total;

  modport source(output valid, output data, output data_valid, output last,
                 output accepted, output batch_end, output fill_level,
                 output dropped_total, input ready);
  modport sink(input valid, input data, input data_valid, input last,
               input accepted, input batch_end, input fill_level,
               input dropped_total, output ready);
endinterface

`default_nettype wire

[rtl/sample_ring_fifo_drop_count.sv]
`default_nettype none
// Channel  Dir  Payload                                                   Handshake
// in_ch    in   kind, sample_bits, batch_last, max_count                  valid/ready
// out_ch   out  data, data_valid, last, accepted, batch_end, fill_level,  valid/ready
//              dropped_total
//
// Push, clear and other requests give one result each; a pop that returns n samples
// reads them through the registered read of the sample memory, then gives one result
// per cycle while out_ch.ready is high. A single result passes the command queue entry
// and the result register after accept; the first sample of a pop also the memory read.
// Reset is synchronous: pointers, drop counter and command queue clear at once;
// the sample memory is left as is. A held result stalls the executor, the
// two-entry command queue fills, then in_ch.ready drops.

module sample_ring_fifo_drop_count #(
  parameter int DEPTH        = srfdc_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = srfdc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  srfdc_in_if.sink      in_ch,
  srfdc_out_if.source   out_ch
);
  import srfdc_pkg::*;

  logic  q_wr, q_full, q_rd, q_not_empty, out_valid;
  cmd_t  q_wdata, q_rdata;
  res_t  out_res;

  srfdc_front u_front (
    .in_ch   (in_ch),
    .q_full  (q_full),
    .q_wr    (q_wr),
    .q_wdata (q_wdata)
  );

  srfdc_cmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (q_wr),
    .wr_data   (q_wdata),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_rdata),
    .not_empty (q_not_empty)
  );

  srfdc_back #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (q_rdata),
    .cmd_take  (q_rd),
    .out_ready (out_ch.ready),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.data          = out_res.data;
  assign out_ch.data_valid    = out_res.data_valid;
  assign out_ch.last          = out_res.last;
  assign out_ch.accepted      = out_res.accepted;
  assign out_ch.batch_end     = out_res.batch_end;
  assign out_ch.fill_level    = out_res.fill_level;
  assign out_ch.dropped_total = out_res.dropped_total;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.data_valid |-> out_ch.data == '0)
    else $error("nonzero data on invalid result");

  a_push_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.accepted || out_ch.batch_end) |->
      out_ch.last && !out_ch.data_valid)
    else $error("push result malformed");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (DEPTH > 64) || (out_ch.fill_level <= 6'(DEPTH - 1)))
    else $error("fill level beyond ring capacity");

  a_take_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> q_not_empty)
    else $error("command taken from empty queue");

endmodule

`default_nettype wire

[rtl/srfdc_ram.sv]
`default_nettype none

module srfdc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/srfdc_cmd_queue.sv]
`default_nettype none

module srfdc_cmd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire srfdc_pkg::cmd_t  wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output srfdc_pkg::cmd_t       rd_data,
  output logic                  not_empty
);
  import srfdc_pkg::*;

  localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [QPW-1:0]   wptr_r, wptr_nxt;
  logic [QPW-1:0]   rptr_r, rptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_wr, do_rd;

  function automatic logic [QPW-1:0] qptr_inc(input logic [QPW-1:0] p);
    return (p == QPW'(QUEUE_DEPTH - 1)) ? '0 : p + QPW'(1);
  endfunction

  assign full      = (count_r == QCW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = entry_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_wr ? qptr_inc(wptr_r) : wptr_r;
    rptr_nxt  = do_rd ? qptr_inc(rptr_r) : rptr_r;
    count_nxt = count_r;
    if (do_wr && !do_rd) begin
      count_nxt = count_r + QCW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - QCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[rtl/srfdc_front.sv]
`default_nettype none

module srfdc_front (
  srfdc_in_if.sink              in_ch,
  input  wire logic             q_full,
  output logic                  q_wr,
  output srfdc_pkg::cmd_t       q_wdata
);
  import srfdc_pkg::*;

  op_t op;

  always_comb begin
    unique case (in_ch.kind)
      KIND_PUSH:  op = OP_PUSH;
      KIND_POP:   op = OP_POP;
      KIND_CLEAR: op = OP_CLEAR;
      default:    op = OP_NOP;
    endcase
  end

  assign in_ch.ready = !q_full;
  assign q_wr        = in_ch.valid && !q_full;

  always_comb begin
    q_wdata.op          = op;
    q_wdata.sample_bits = in_ch.sample_bits;
    q_wdata.batch_last  = in_ch.batch_last;
    q_wdata.max_count   = in_ch.max_count;
  end

endmodule

`default_nettype wire

[rtl/srfdc_back.sv]
`default_nettype none

module srfdc_back #(
  parameter int DEPTH        = srfdc_pkg::DEPTH_DEF,
  parameter int SAMPLE_WIDTH = srfdc_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cmd_valid,
  input  wire srfdc_pkg::cmd_t  cmd,
  output logic                  cmd_take,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output srfdc_pkg::res_t       out_res
);
  import srfdc_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int MW = (PW > MAXC_W) ? PW : MAXC_W;

  back_state_t         state_r, state_nxt;
  logic [PW-1:0]       wp_r, wp_nxt;
  logic [PW-1:0]       rp_r, rp_nxt;
  logic [DROP_W-1:0]   drop_r, drop_nxt;
  logic [MAXC_W-1:0]   remain_r, remain_nxt;
  logic                out_valid_r, out_valid_nxt;
  res_t                out_r, res_nxt;

  logic [PW:0]         wp_x, rp_x, fsum;
  logic [PW-1:0]       fill_cur;
  logic                full;
  logic [MAXC_W-1:0]   n_pop;
  logic                can_load, take, load;
  logic                ram_we, ram_re;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wp_x     = {1'b0, wp_r};
  assign rp_x     = {1'b0, rp_r};
  assign fsum     = (wp_x >= rp_x) ? (wp_x - rp_x) : (wp_x + (PW+1)'(DEPTH) - rp_x);
  assign fill_cur = fsum[PW-1:0];
  assign full     = (fill_cur == PW'(DEPTH - 1));
  assign n_pop    = (MW'(fill_cur) < MW'(cmd.max_count)) ? MAXC_W'(fill_cur) : cmd.max_count;

  assign can_load  = !out_valid_r || out_ready;
  assign take      = (state_r == BS_IDLE) && cmd_valid && can_load;
  assign cmd_take  = take;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE: begin
        if (take && cmd.op == OP_POP && n_pop != '0) begin
          state_nxt = BS_POP;
        end
      end
      BS_POP: begin
        if (can_load && remain_r == '0) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    drop_nxt   = drop_r;
    remain_nxt = remain_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    res_nxt.data          = '0;
    res_nxt.data_valid    = 1'b0;
    res_nxt.last          = 1'b1;
    res_nxt.accepted      = 1'b0;
    res_nxt.batch_end     = 1'b0;
    res_nxt.fill_level    = FILL_W'(fill_cur);
    res_nxt.dropped_total = drop_r;
    unique case (state_r)
      BS_IDLE: begin
        if (take) begin
          unique case (cmd.op)
            OP_PUSH: begin
              load              = 1'b1;
              res_nxt.batch_end = cmd.batch_last;
              if (!full) begin
                ram_we             = 1'b1;
                wp_nxt             = ptr_inc(wp_r);
                res_nxt.accepted   = 1'b1;
                res_nxt.fill_level = FILL_W'(fill_cur + PW'(1));
              end else begin
                drop_nxt              = drop_r + DROP_W'(1);
                res_nxt.dropped_total = drop_r + DROP_W'(1);
              end
            end
            OP_POP: begin
              if (n_pop == '0) begin
                load = 1'b1;
              end else begin
                ram_re     = 1'b1;
                rp_nxt     = ptr_inc(rp_r);
                remain_nxt = n_pop - MAXC_W'(1);
              end
            end
            OP_CLEAR: begin
              load                  = 1'b1;
              wp_nxt                = '0;
              rp_nxt                = '0;
              drop_nxt              = '0;
              res_nxt.fill_level    = '0;
              res_nxt.dropped_total = '0;
            end
            OP_NOP: begin
              load = 1'b1;
            end
          endcase
        end
      end
      BS_POP: begin
        if (can_load) begin
          load               = 1'b1;
          res_nxt.data       = DATA_W'(ram_rdata);
          res_nxt.data_valid = 1'b1;
          res_nxt.last       = (remain_r == '0);
          if (remain_r != '0) begin
            ram_re     = 1'b1;
            rp_nxt     = ptr_inc(rp_r);
            remain_nxt = remain_r - MAXC_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      drop_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      drop_r      <= drop_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res_nxt;
    end
  end

  srfdc_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (SAMPLE_WIDTH'(cmd.sample_bits)),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire
